// ===== rtl/rsort_pkg.sv =====
package rsort_pkg;

  // One buffered record; the identifier sits in the lowest bits
  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] salary;
    logic [30:0] id;
  } rsort_rec_t;

  localparam int unsigned REC_W = $bits(rsort_rec_t);

  // Source of the data written into the record store
  typedef enum logic [1:0] {
    WR_INPUT   = 2'd0,
    WR_SMALLER = 2'd1,
    WR_HELD    = 2'd2
  } rsort_wr_src_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic          ram_we;
    rsort_wr_src_t wr_src;
    logic          held_load;
    logic          held_step;
    logic          out_load;
    logic          out_last;
    logic          drop_set;
    logic          drop_clear;
  } rsort_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_taken;
  } rsort_sts_t;

endpackage

// ===== rtl/rsort_ram.sv =====
module rsort_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rsort_dp.sv =====
module rsort_dp
  import rsort_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  rsort_rec_t                     in_rec,
  input  rsort_cmd_t                     cmd,
  input  logic [$clog2(MAX_RECORDS)-1:0] waddr,
  input  logic [$clog2(MAX_RECORDS)-1:0] raddr,
  output rsort_sts_t                     sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rsort_rec_t                     out_rec,
  output logic                           out_last,
  output logic                           out_overflow
);

  logic       sort_mode;
  logic       dropped;
  rsort_rec_t held;
  rsort_rec_t rdata;
  rsort_rec_t wdata;
  logic       swap;

  rsort_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Held record must move behind the one just read
  always_comb begin
    if (sort_mode) begin
      swap = held.salary < rdata.salary;
    end else begin
      swap = held.id > rdata.id;
    end
  end

  // Select the word written back to the store
  always_comb begin
    case (cmd.wr_src)
      WR_INPUT:   wdata = in_rec;
      WR_SMALLER: wdata = swap ? rdata : held;
      WR_HELD:    wdata = held;
      default:    wdata = in_rec;
    endcase
  end

  // Carry the bubbling record through a pass
  always_ff @(posedge clk) begin
    if (cmd.held_load || (cmd.held_step && !swap)) begin
      held <= rdata;
    end
  end

  // Hold mode register and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      if (cfg_we) begin
        sort_mode <= cfg_wdata;
      end
      if (cmd.drop_clear) begin
        dropped <= 1'b0;
      end else if (cmd.drop_set) begin
        dropped <= 1'b1;
      end
    end
  end

  // Output register: load a beat, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rec      <= rdata;
      out_last     <= cmd.out_last;
      out_overflow <= dropped;
    end
  end

  assign sts.out_taken = out_valid && out_ready;

endmodule

// ===== rtl/rsort_ctrl.sv =====
module rsort_ctrl
  import rsort_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_fire,
  input  logic                           in_last,
  input  rsort_sts_t                     sts,
  output logic                           in_ready,
  output rsort_cmd_t                     cmd,
  output logic [$clog2(MAX_RECORDS)-1:0] waddr,
  output logic [$clog2(MAX_RECORDS)-1:0] raddr
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);
  localparam logic [AW-1:0] TOP  = AW'(MAX_RECORDS - 1);
  localparam logic [AW-1:0] ONE  = AW'(1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD0,
    ST_LD0,
    ST_CMP,
    ST_END,
    ST_ERD,
    ST_EWAIT,
    ST_EHOLD
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] lim;
  logic [AW-1:0] top;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  logic          has_room;
  logic [AW-1:0] new_top;

  assign has_room = count < FULL;
  assign new_top  = has_room ? count[AW-1:0] : TOP;
  assign in_ready = (state == ST_LOAD);

  // Sequence load, sort passes and emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      lim   <= '0;
      top   <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (has_room) begin
              count <= count + CW'(1);
            end
            if (in_last) begin
              top <= new_top;
              lim <= new_top;
              k   <= '0;
              if (new_top == '0) begin
                state <= ST_ERD;
              end else begin
                state <= ST_RD0;
              end
            end
          end
        end
        ST_RD0: begin
          state <= ST_LD0;
        end
        ST_LD0: begin
          j     <= '0;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (j + ONE == lim) begin
            state <= ST_END;
          end else begin
            j <= j + ONE;
          end
        end
        ST_END: begin
          lim <= lim - ONE;
          if (lim == ONE) begin
            k     <= '0;
            state <= ST_ERD;
          end else begin
            state <= ST_RD0;
          end
        end
        ST_ERD: begin
          state <= ST_EWAIT;
        end
        ST_EWAIT: begin
          state <= ST_EHOLD;
        end
        ST_EHOLD: begin
          if (sts.out_taken) begin
            if (k == top) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + ONE;
              state <= ST_ERD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Decode commands and store addresses
  always_comb begin
    cmd        = '0;
    cmd.wr_src = WR_INPUT;
    waddr      = count[AW-1:0];
    raddr      = '0;
    case (state)
      ST_LOAD: begin
        cmd.ram_we   = in_fire && has_room;
        cmd.drop_set = in_fire && !has_room;
      end
      ST_RD0: begin
        raddr = '0;
      end
      ST_LD0: begin
        cmd.held_load = 1'b1;
        raddr         = ONE;
      end
      ST_CMP: begin
        cmd.ram_we    = 1'b1;
        cmd.wr_src    = WR_SMALLER;
        cmd.held_step = 1'b1;
        waddr         = j;
        raddr         = j + ONE + ONE;
      end
      ST_END: begin
        cmd.ram_we = 1'b1;
        cmd.wr_src = WR_HELD;
        waddr      = lim;
      end
      ST_ERD: begin
        raddr = k;
      end
      ST_EWAIT: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (k == top);
        raddr        = k;
      end
      ST_EHOLD: begin
        cmd.drop_clear = sts.out_taken && (k == top);
        raddr          = k;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/record_sorter_two_key_core.sv =====
// Two-key record sorter.
// Slave stream (s_*): one record per beat, s_tlast marks the final record of
// a set. Records are stored in a 32-deep (MAX_RECORDS) store; records beyond
// capacity are dropped and the set is flagged on m_tuser.
// Master stream (m_*): after the last input beat the set is bubble sorted in
// place and emitted, m_tlast on the final record. cfg_we/cfg_wdata write the
// sort mode: 0 identifier ascending, 1 salary descending, stable on ties.
// Input beats are taken one per cycle while loading. Sorting n records runs
// n-1 passes over the store (one read and one write port), with one read and
// one write of the store per compare. Each record is emitted in turn by a
// store read, an output register load and the beat; the next record is read
// only after the current beat is taken. s_tready is low from the last input
// beat until the final output beat is taken.
// When the receiver stalls, the output register holds the beat and emission
// waits; nothing is lost. Reset (rst, synchronous) empties the buffer,
// clears the drop flag and sets the mode to identifier ascending; store
// contents are not cleared.
module record_sorter_two_key_core
  import rsort_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // record_id[30:0], salary_cents[62:31], record_tag[78:63], zero[79]
  input  logic [79:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_id[30:0], out_salary[62:31], out_tag[78:63], zero[79]
  output logic [79:0] m_tdata,
  output logic        m_tlast,
  // overflow[0]
  output logic        m_tuser
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);

  rsort_cmd_t    cmd;
  rsort_sts_t    sts;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rsort_rec_t    in_rec;
  rsort_rec_t    out_rec;
  logic          in_fire;

  assign in_rec  = s_tdata[REC_W-1:0];
  assign in_fire = s_tvalid && s_tready;
  assign m_tdata = {1'b0, out_rec};

  rsort_ctrl #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_last (s_tlast),
    .sts     (sts),
    .in_ready(s_tready),
    .cmd     (cmd),
    .waddr   (waddr),
    .raddr   (raddr)
  );

  rsort_dp #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_rec      (in_rec),
    .cmd         (cmd),
    .waddr       (waddr),
    .raddr       (raddr),
    .sts         (sts),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_rec     (out_rec),
    .out_last    (m_tlast),
    .out_overflow(m_tuser)
  );

endmodule

// ===== verif/record_sorter_checker.sv =====
`timescale 1ns / 1ps
module record_sorter_checker
  import rsort_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending,
  output int          beats_checked
);

  // One expected output beat of a sorted set
  typedef struct {
    rsort_rec_t rec;
    logic       is_last;
    logic       ovf;
  } sorted_beat_t;

  rsort_rec_t   loaded_recs[$];
  sorted_beat_t sorted_beats[$];
  logic         by_salary;
  logic         drop_seen;

  // True when record a has to move behind record b (strict, so ties stay put)
  function automatic bit goes_behind(input rsort_rec_t a, input rsort_rec_t b);
    if (by_salary)
      return a.salary < b.salary;
    return a.id > b.id;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] sorted beat %0d: %s expected 0x%0h got 0x%0h",
                 $realtime, beats_checked, field, want, got);
    end
  endtask

  // Buffer one record; on the set's last beat sort the set and queue its beats
  task automatic take_record(input rsort_rec_t rec, input logic is_last);
    rsort_rec_t ordered[$];
    rsort_rec_t hold;
    if (loaded_recs.size() < MAX_RECORDS)
      loaded_recs.push_back(rec);
    else
      drop_seen = 1'b1;
    if (is_last) begin
      ordered = loaded_recs;
      for (int pass = 0; pass + 1 < ordered.size(); pass++) begin
        for (int j = 0; j + 1 < ordered.size() - pass; j++) begin
          if (goes_behind(ordered[j], ordered[j + 1])) begin
            hold = ordered[j];
            ordered[j] = ordered[j + 1];
            ordered[j + 1] = hold;
          end
        end
      end
      foreach (ordered[k])
        sorted_beats.push_back('{rec: ordered[k], is_last: (k == ordered.size() - 1),
                                 ovf: drop_seen});
      loaded_recs.delete();
      drop_seen = 1'b0;
    end
  endtask

  // Compare one output beat with the oldest expected beat
  task automatic check_beat();
    sorted_beat_t want;
    rsort_rec_t   got;
    got = m_tdata[78:0];
    if (sorted_beats.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected sorted beat: id 0x%0h salary 0x%0h tag 0x%0h",
                 $realtime, got.id, got.salary, got.tag);
    end else begin
      want = sorted_beats.pop_front();
      flag_field("id", {1'b0, want.rec.id}, {1'b0, got.id});
      flag_field("salary", want.rec.salary, got.salary);
      flag_field("tag", {16'd0, want.rec.tag}, {16'd0, got.tag});
      flag_field("last", {31'd0, want.is_last}, {31'd0, m_tlast});
      flag_field("overflow", {31'd0, want.ovf}, {31'd0, m_tuser});
    end
    beats_checked++;
  endtask

  // Watch both streams and the mode register at every edge
  always @(posedge clk) begin
    if (rst) begin
      loaded_recs.delete();
      sorted_beats.delete();
      by_salary = 1'b0;
      drop_seen = 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        check_beat();
      if (s_tvalid && s_tready)
        take_record(s_tdata[78:0], s_tlast);
      if (cfg_we)
        by_salary = cfg_wdata;
    end
    pending = sorted_beats.size();
  end

endmodule

// ===== verif/tb_record_sorter_two_key_core.sv =====
`timescale 1ns / 1ps
module tb_record_sorter_two_key_core;
  import rsort_pkg::*;

  localparam int unsigned MAX_RECORDS  = 32;
  localparam int          RANDOM_ITEMS = 190;
  localparam int          QUIET_ITEMS  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [79:0] m_tdata;
  wire         m_tlast;
  wire         m_tuser;

  int fail_count;
  int pending;
  int beats_checked;
  logic quiet = 1'b0;
  int ready_run = 0;
  int records_sent = 0;
  int sets_sent = 0;
  int salary_sets = 0;
  int overflow_sets = 0;
  rsort_rec_t set_recs[$];

  always #2 clk = ~clk;

  record_sorter_two_key_core #(.MAX_RECORDS(MAX_RECORDS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  record_sorter_checker #(.MAX_RECORDS(MAX_RECORDS)) sort_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .fail_count(fail_count), .pending(pending),
    .beats_checked(beats_checked)
  );

  // Stall the output side in bursts of random length; hold ready once quiet
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_run <= 0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      ready_run <= $urandom_range(1, 10) - 1;
    end else begin
      m_tready <= 1'b1;
      ready_run <= $urandom_range(0, 15);
    end
  end

  // Field values weighted toward ties and extremes
  function automatic rsort_rec_t rand_rec();
    rsort_rec_t rec;
    case ($urandom_range(0, 7))
      0, 1:    rec.id = 31'($urandom_range(0, 7));
      2:       rec.id = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      default: rec.id = 31'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    rec.salary = $urandom_range(0, 5);
      2:       rec.salary = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: rec.salary = $urandom;
    endcase
    rec.tag = 16'($urandom);
    return rec;
  endfunction

  // Present one record, with an optional gap before it, and wait for the beat
  task automatic send_record(input rsort_rec_t rec, input logic is_last);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, rec};
    s_tlast <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    records_sent++;
  endtask

  // Write the mode, load the set, then wait until its sorted beats are all out
  task automatic run_set(input logic mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    foreach (set_recs[k])
      send_record(set_recs[k], k == set_recs.size() - 1);
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    sets_sent++;
    if (mode)
      salary_sets++;
    if (set_recs.size() > MAX_RECORDS)
      overflow_sets++;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    set_recs.delete();
  endtask

  task automatic add_rec(input logic [30:0] id, input logic [31:0] salary,
                         input logic [15:0] tag);
    set_recs.push_back('{tag: tag, salary: salary, id: id});
  endtask

  initial begin
    int random_sent;
    int set_idx;
    int set_size;
    int pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes and equal identifiers, identifier order
    add_rec(31'h7FFF_FFFF, 32'd0, 16'h0000);
    add_rec(31'd0, 32'hFFFF_FFFF, 16'hFFFF);
    add_rec(31'd9, 32'd100, 16'h0001);
    add_rec(31'd9, 32'd100, 16'h0002);
    add_rec(31'd1, 32'd100, 16'h0003);
    run_set(1'b1 ^ 1'b1);
    // Same records, salary order with equal salaries
    add_rec(31'h7FFF_FFFF, 32'd0, 16'h0000);
    add_rec(31'd0, 32'hFFFF_FFFF, 16'hFFFF);
    add_rec(31'd9, 32'd100, 16'h0001);
    add_rec(31'd9, 32'd100, 16'h0002);
    add_rec(31'd1, 32'd100, 16'h0003);
    run_set(1'b1);
    // Single-record set
    add_rec(31'h2AAA_AAAA, 32'h5555_5555, 16'hA5A5);
    run_set(1'b1);
    // Identical records around a smaller one
    add_rec(31'd3, 32'd7, 16'h1234);
    add_rec(31'd2, 32'd8, 16'h4321);
    add_rec(31'd3, 32'd7, 16'h1234);
    run_set(1'b0);
    // Reversed identifiers
    for (int k = 5; k >= 1; k--)
      add_rec(31'(k), $urandom, 16'($urandom));
    run_set(1'b0);

    // Random sets, mostly small; one over capacity and one exactly full
    random_sent = 0;
    set_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - random_sent <= QUIET_ITEMS)
        quiet <= 1'b1;
      pick = $urandom_range(0, 19);
      if (set_idx == 2)
        set_size = MAX_RECORDS + 1 + $urandom_range(0, 2);
      else if (set_idx == 5)
        set_size = MAX_RECORDS;
      else if (pick == 0)
        set_size = MAX_RECORDS - 1;
      else
        set_size = $urandom_range(1, 10);
      for (int k = 0; k < set_size; k++)
        set_recs.push_back(rand_rec());
      run_set(1'($urandom_range(0, 1)));
      random_sent += set_size;
      set_idx++;
    end

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d records in %0d sets (%0d by salary, %0d over capacity)",
             records_sent, sets_sent, salary_sets, overflow_sets);
    $display("Checked %0d sorted beats, %0d mismatches", beats_checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
